[design/notch_coefficient_generator_defines.svh]
// ----------------------------------------------------------------------------
// notch_coefficient_generator_defines.svh
// Assertion macros shared by the notch coefficient generator.
// ----------------------------------------------------------------------------
`ifndef NOTCH_COEFFICIENT_GENERATOR_DEFINES_SVH
`define NOTCH_COEFFICIENT_GENERATOR_DEFINES_SVH

// Clocked assertion, muted while reset is held
`define NCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication
`define NCG_ASSERT_IMPLY(label, ante, cons, msg) \
    `NCG_ASSERT(label, (ante) |-> (cons), msg)

`endif

[design/ncg_pkg.sv]
// ----------------------------------------------------------------------------
// ncg_pkg
// Widths, status codes, CORDIC angle table and side-band types for the
// notch coefficient generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ncg_pkg;

    localparam int RATE_W   = 16;
    localparam int FREQ_W   = 24;
    localparam int DAMP_W   = 16;
    localparam int COEF_W   = 32;
    localparam int QUO_W    = 32;   // quotient bits of every divider chain
    localparam int CORDIC_W = 33;   // signed x, y, z width
    localparam int SC_W     = 24;   // clamped sin/cos magnitude
    localparam int SQ_W     = 48;
    localparam int WIDE_W   = 64;

    localparam int TAN_STAGES_DEF = 24;

    localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_HALF  = 2'd1,
        ST_DZERO = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    // side-band through the rate divider and the CORDIC
    typedef struct packed {
        logic              half;
        logic [DAMP_W-1:0] damp;
    } t_front;

    // side-band of the b0 ratio lane
    typedef struct packed {
        t_status pre;
        logic    ovf;
    } t_lead;

    // side-band of a signed ratio lane
    typedef struct packed {
        logic neg;
        logic ovf;
    } t_sign;

endpackage

`default_nettype wire

[design/ncg_div_cell.sv]
// ----------------------------------------------------------------------------
// ncg_div_cell
// One restoring-division step: shifts in one dividend bit, subtracts the
// divisor where it fits and appends one quotient bit. Registered outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module ncg_div_cell #(
    parameter int DW = 16,
    parameter int QW = 32,
    parameter int FW = 32,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [QW-1:0] i_quo,
    input  wire logic [FW-1:0] i_feed,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic      [DW-1:0] o_rem,
    output logic      [DW-1:0] o_div,
    output logic      [QW-1:0] o_quo,
    output logic      [FW-1:0] o_feed,
    output logic      [SW-1:0] o_side
);

    logic          r_valid;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_quo, n_quo;
    logic [FW-1:0] r_feed, n_feed;
    logic [SW-1:0] r_side;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;

    // trial subtract
    always_comb begin
        w_trial = {i_rem, i_feed[FW-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_quo   = {i_quo[QW-2:0], w_ge};
        n_feed  = {i_feed[FW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= i_div;
        r_quo  <= n_quo;
        r_feed <= n_feed;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;
    assign o_feed  = r_feed;
    assign o_side  = r_side;

endmodule

`default_nettype wire

[design/ncg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ncg_cordic_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift IDX and its
// arctangent constant. Registered outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module ncg_cordic_cell #(
    parameter int IDX = 0,
    parameter int SW  = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [ncg_pkg::CORDIC_W-1:0] i_x,
    input  wire logic signed [ncg_pkg::CORDIC_W-1:0] i_y,
    input  wire logic signed [ncg_pkg::CORDIC_W-1:0] i_z,
    input  wire logic        [SW-1:0]                i_side,
    output logic                                     o_valid,
    output logic signed      [ncg_pkg::CORDIC_W-1:0] o_x,
    output logic signed      [ncg_pkg::CORDIC_W-1:0] o_y,
    output logic signed      [ncg_pkg::CORDIC_W-1:0] o_z,
    output logic             [SW-1:0]                o_side
);

    localparam logic signed [ncg_pkg::CORDIC_W-1:0] ANGLE =
        {{(ncg_pkg::CORDIC_W-32){1'b0}}, ncg_pkg::ATAN_Q30[IDX]};

    logic                                r_valid;
    logic signed [ncg_pkg::CORDIC_W-1:0] r_x, n_x;
    logic signed [ncg_pkg::CORDIC_W-1:0] r_y, n_y;
    logic signed [ncg_pkg::CORDIC_W-1:0] r_z, n_z;
    logic        [SW-1:0]                r_side;

    // rotate toward zero residual angle; >>> is the floor shift
    always_comb begin
        if (!i_z[ncg_pkg::CORDIC_W-1]) begin
            n_x = i_x - (i_y >>> IDX);
            n_y = i_y + (i_x >>> IDX);
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + (i_y >>> IDX);
            n_y = i_y - (i_x >>> IDX);
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

[design/notch_coefficient_generator.sv]
// ----------------------------------------------------------------------------
// notch_coefficient_generator
// Second-order notch coefficients from a notch frequency and a damping
// setting, prewarped bilinear design, Q3.28 outputs with status.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  ------    --------------------------  -----------------------------------
//  request   start / busy                i_notch_freq, i_damping
//  config    i_cfg_valid / o_cfg_ready   i_cfg_data (sample rate)
//  result    o_result_valid (strobe)     o_num_outer .. o_den_second, o_status
//
//  One item enters per cycle; every item passes a 32-step rate divider chain,
//  TAN_STAGES CORDIC cells, 32-step ratio divider chains and six single
//  stages. busy is high during reset and until the ready register is set.
//  Reset clears all valid bits and sets the sample rate to 1.
//  Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "notch_coefficient_generator_defines.svh"

module notch_coefficient_generator #(
    parameter int TAN_STAGES = ncg_pkg::TAN_STAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic        [ncg_pkg::FREQ_W-1:0] i_notch_freq,
    input  wire logic        [ncg_pkg::DAMP_W-1:0] i_damping,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic        [ncg_pkg::RATE_W-1:0] i_cfg_data,
    output logic                                   o_result_valid,
    output logic signed      [ncg_pkg::COEF_W-1:0] o_num_outer,
    output logic signed      [ncg_pkg::COEF_W-1:0] o_num_middle,
    output logic signed      [ncg_pkg::COEF_W-1:0] o_den_first,
    output logic signed      [ncg_pkg::COEF_W-1:0] o_den_second,
    output logic             [1:0]                 o_status
);

    localparam int QW  = ncg_pkg::QUO_W;
    localparam int CW  = ncg_pkg::CORDIC_W;
    localparam int WW  = ncg_pkg::WIDE_W;
    localparam int RW  = ncg_pkg::RATE_W;
    localparam int LAT = TAN_STAGES + 2 * QW + 6;

    typedef struct packed {
        logic                      sat;
        logic [ncg_pkg::COEF_W-1:0] val;
    } t_pack;

    // round Q29 magnitude to Q28 and apply sign with saturation
    function automatic t_pack pack_q28(input logic neg, input logic ovf,
                                       input logic [QW-1:0] q);
        logic [QW:0] mag;
        logic [QW:0] tmp;
        t_pack       res;
        mag = ovf ? {1'b1, {QW{1'b0}}} : ({1'b0, q} + 33'd1) >> 1;
        tmp = 33'd0 - mag;
        if (!neg) begin
            res.sat = (mag > 33'h0_7FFF_FFFF);
            res.val = res.sat ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            res.sat = (mag > 33'h0_8000_0000);
            res.val = res.sat ? 32'h8000_0000 : tmp[31:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // control: ready after reset, sample rate register
    logic          r_rdy;
    logic [RW-1:0] r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
            r_fs  <= 16'd1;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_valid && r_rdy) begin
                r_fs <= i_cfg_data;
            end
        end
    end

    assign busy        = !r_rdy;
    assign o_cfg_ready = r_rdy;

    // ------------------------------------------------------------------
    // rate divider: r = floor(f * 2^25 / fs), one quotient bit per cell
    logic            w_acc;
    ncg_pkg::t_front w_front;

    logic                  w_rv    [0:QW];
    logic [RW-1:0]         w_rrem  [0:QW];
    logic [RW-1:0]         w_rdiv  [0:QW];
    logic [QW-1:0]         w_rquo  [0:QW];
    logic [QW-1:0]         w_rfeed [0:QW];
    ncg_pkg::t_front       w_rside [0:QW];

    always_comb begin
        w_acc         = start && r_rdy;
        w_front.half  = (r_fs == '0) || (i_notch_freq >= {1'b0, r_fs, 7'd0});
        w_front.damp  = i_damping;
    end

    assign w_rv[0]    = w_acc;
    assign w_rrem[0]  = i_notch_freq[22:7];
    assign w_rdiv[0]  = r_fs;
    assign w_rquo[0]  = '0;
    assign w_rfeed[0] = {i_notch_freq[6:0], 25'd0};
    assign w_rside[0] = w_front;

    for (genvar g = 0; g < QW; g++) begin : g_rate
        ncg_div_cell #(
            .DW(RW), .QW(QW), .FW(QW), .SW($bits(ncg_pkg::t_front))
        ) u_cell (
            .i_clk  (i_clk),       .i_rst_n(i_rst_n),
            .i_valid(w_rv[g]),     .i_rem  (w_rrem[g]),
            .i_div  (w_rdiv[g]),   .i_quo  (w_rquo[g]),
            .i_feed (w_rfeed[g]),  .i_side (w_rside[g]),
            .o_valid(w_rv[g+1]),   .o_rem  (w_rrem[g+1]),
            .o_div  (w_rdiv[g+1]), .o_quo  (w_rquo[g+1]),
            .o_feed (w_rfeed[g+1]), .o_side(w_rside[g+1])
        );
    end

    // ------------------------------------------------------------------
    // angle: theta = r * pi/2 in Q30
    logic            r_th_vld;
    logic [30:0]     r_theta;
    ncg_pkg::t_front r_th_side;
    logic [63:0]     w_thprod;

    assign w_thprod = 64'(w_rquo[QW]) * 64'(ncg_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        r_theta   <= w_thprod[62:32];
        r_th_side <= w_rside[QW];
    end

    // ------------------------------------------------------------------
    // CORDIC chain
    logic                   w_cv    [0:TAN_STAGES];
    logic signed [CW-1:0]   w_cx    [0:TAN_STAGES];
    logic signed [CW-1:0]   w_cy    [0:TAN_STAGES];
    logic signed [CW-1:0]   w_cz    [0:TAN_STAGES];
    ncg_pkg::t_front        w_cside [0:TAN_STAGES];

    assign w_cv[0]    = r_th_vld;
    assign w_cx[0]    = 33'sh0_2000_0000;
    assign w_cy[0]    = '0;
    assign w_cz[0]    = {2'b00, r_theta};
    assign w_cside[0] = r_th_side;

    for (genvar g = 0; g < TAN_STAGES; g++) begin : g_cordic
        ncg_cordic_cell #(
            .IDX(g), .SW($bits(ncg_pkg::t_front))
        ) u_cell (
            .i_clk  (i_clk),      .i_rst_n(i_rst_n),
            .i_valid(w_cv[g]),    .i_x    (w_cx[g]),
            .i_y    (w_cy[g]),    .i_z    (w_cz[g]),
            .i_side (w_cside[g]),
            .o_valid(w_cv[g+1]),  .o_x    (w_cx[g+1]),
            .o_y    (w_cy[g+1]),  .o_z    (w_cz[g+1]),
            .o_side (w_cside[g+1])
        );
    end

    // ------------------------------------------------------------------
    // clamp negative results to zero and drop seven bits
    logic                        r_cl_vld;
    logic [ncg_pkg::SC_W-1:0]    r_cl_s, r_cl_c;
    ncg_pkg::t_front             r_cl_side;

    always_ff @(posedge i_clk) begin
        r_cl_c    <= w_cx[TAN_STAGES][CW-1] ? '0 : w_cx[TAN_STAGES][30:7];
        r_cl_s    <= w_cy[TAN_STAGES][CW-1] ? '0 : w_cy[TAN_STAGES][30:7];
        r_cl_side <= w_cside[TAN_STAGES];
    end

    // ------------------------------------------------------------------
    // squares and cross product
    logic                     r_m_vld;
    logic [ncg_pkg::SQ_W-1:0] r_m_s2, r_m_c2, r_m_sc;
    ncg_pkg::t_front          r_m_side;

    always_ff @(posedge i_clk) begin
        r_m_s2   <= 48'(r_cl_s) * 48'(r_cl_s);
        r_m_c2   <= 48'(r_cl_c) * 48'(r_cl_c);
        r_m_sc   <= 48'(r_cl_s) * 48'(r_cl_c);
        r_m_side <= r_cl_side;
    end

    // ------------------------------------------------------------------
    // P = s^2 + c^2, T = damping * s * c, |s^2 - c^2|
    logic                     r_pt_vld;
    logic [WW-1:0]            r_pt_p, r_pt_t;
    logic [ncg_pkg::SQ_W-1:0] r_pt_diff;
    logic                     r_pt_neg;
    logic                     r_pt_half;

    always_ff @(posedge i_clk) begin
        r_pt_p    <= 64'(r_m_s2) + 64'(r_m_c2);
        r_pt_t    <= 64'(r_m_side.damp) * 64'(r_m_sc);
        r_pt_neg  <= (r_m_s2 < r_m_c2);
        r_pt_diff <= (r_m_s2 < r_m_c2) ? (r_m_c2 - r_m_s2) : (r_m_s2 - r_m_c2);
        r_pt_half <= r_m_side.half;
    end

    // ------------------------------------------------------------------
    // numerators and the shared denominator
    logic            r_nm_vld;
    logic [WW-1:0]   r_nm_n0, r_nm_n1, r_nm_n2, r_nm_d;
    logic            r_nm_neg1, r_nm_neg2;
    ncg_pkg::t_status r_nm_pre;
    logic [WW-1:0]   w_a, w_d;

    always_comb begin
        w_a = r_pt_p * 64'd2560;
        w_d = w_a + r_pt_t;
    end

    always_ff @(posedge i_clk) begin
        r_nm_n0   <= w_a;
        r_nm_n1   <= 64'(r_pt_diff) * 64'd5120;
        r_nm_neg1 <= r_pt_neg;
        r_nm_neg2 <= (r_pt_t > w_a);
        r_nm_n2   <= (r_pt_t > w_a) ? (r_pt_t - w_a) : (w_a - r_pt_t);
        r_nm_d    <= w_d;
        if (r_pt_half) begin
            r_nm_pre <= ncg_pkg::ST_HALF;
        end else if (w_d == '0) begin
            r_nm_pre <= ncg_pkg::ST_DZERO;
        end else begin
            r_nm_pre <= ncg_pkg::ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // ratio divider chains: floor(n * 2^29 / d), three lanes
    logic [WW-1:0]  w_num [0:2];
    logic           w_ovf [0:2];

    assign w_num[0] = r_nm_n0;
    assign w_num[1] = r_nm_n1;
    assign w_num[2] = r_nm_n2;

    for (genvar k = 0; k < 3; k++) begin : g_ovf
        assign w_ovf[k] = ({3'b000, w_num[k]} >= {r_nm_d, 3'b000});
    end

    ncg_pkg::t_lead w_lead0;
    ncg_pkg::t_sign w_sgn1, w_sgn2;

    always_comb begin
        w_lead0.pre = r_nm_pre;
        w_lead0.ovf = w_ovf[0];
        w_sgn1.neg  = r_nm_neg1;
        w_sgn1.ovf  = w_ovf[1];
        w_sgn2.neg  = r_nm_neg2;
        w_sgn2.ovf  = w_ovf[2];
    end

    logic           w_qv  [0:QW];
    logic [WW-1:0]  w_qrem [0:2][0:QW];
    logic [WW-1:0]  w_qdiv [0:2][0:QW];
    logic [QW-1:0]  w_qquo [0:2][0:QW];
    logic [QW-1:0]  w_qfeed[0:2][0:QW];
    ncg_pkg::t_lead w_ls   [0:QW];
    ncg_pkg::t_sign w_s1   [0:QW];
    ncg_pkg::t_sign w_s2   [0:QW];

    assign w_qv[0] = r_nm_vld;
    assign w_ls[0] = w_lead0;
    assign w_s1[0] = w_sgn1;
    assign w_s2[0] = w_sgn2;

    for (genvar k = 0; k < 3; k++) begin : g_lane_init
        assign w_qrem[k][0]  = {3'b000, w_num[k][WW-1:3]};
        assign w_qdiv[k][0]  = r_nm_d;
        assign w_qquo[k][0]  = '0;
        assign w_qfeed[k][0] = {w_num[k][2:0], 29'd0};
    end

    for (genvar g = 0; g < QW; g++) begin : g_ratio
        ncg_div_cell #(
            .DW(WW), .QW(QW), .FW(QW), .SW($bits(ncg_pkg::t_lead))
        ) u_lane0 (
            .i_clk  (i_clk),           .i_rst_n(i_rst_n),
            .i_valid(w_qv[g]),         .i_rem  (w_qrem[0][g]),
            .i_div  (w_qdiv[0][g]),    .i_quo  (w_qquo[0][g]),
            .i_feed (w_qfeed[0][g]),   .i_side (w_ls[g]),
            .o_valid(w_qv[g+1]),       .o_rem  (w_qrem[0][g+1]),
            .o_div  (w_qdiv[0][g+1]),  .o_quo  (w_qquo[0][g+1]),
            .o_feed (w_qfeed[0][g+1]), .o_side (w_ls[g+1])
        );
        ncg_div_cell #(
            .DW(WW), .QW(QW), .FW(QW), .SW($bits(ncg_pkg::t_sign))
        ) u_lane1 (
            .i_clk  (i_clk),           .i_rst_n(i_rst_n),
            .i_valid(w_qv[g]),         .i_rem  (w_qrem[1][g]),
            .i_div  (w_qdiv[1][g]),    .i_quo  (w_qquo[1][g]),
            .i_feed (w_qfeed[1][g]),   .i_side (w_s1[g]),
            .o_valid(),                .o_rem  (w_qrem[1][g+1]),
            .o_div  (w_qdiv[1][g+1]),  .o_quo  (w_qquo[1][g+1]),
            .o_feed (w_qfeed[1][g+1]), .o_side (w_s1[g+1])
        );
        ncg_div_cell #(
            .DW(WW), .QW(QW), .FW(QW), .SW($bits(ncg_pkg::t_sign))
        ) u_lane2 (
            .i_clk  (i_clk),           .i_rst_n(i_rst_n),
            .i_valid(w_qv[g]),         .i_rem  (w_qrem[2][g]),
            .i_div  (w_qdiv[2][g]),    .i_quo  (w_qquo[2][g]),
            .i_feed (w_qfeed[2][g]),   .i_side (w_s2[g]),
            .o_valid(),                .o_rem  (w_qrem[2][g+1]),
            .o_div  (w_qdiv[2][g+1]),  .o_quo  (w_qquo[2][g+1]),
            .o_feed (w_qfeed[2][g+1]), .o_side (w_s2[g+1])
        );
    end

    // ------------------------------------------------------------------
    // rounding, sign, saturation and status
    t_pack w_p0, w_p1, w_p2;
    logic  w_sat;
    logic  w_zero;

    always_comb begin
        w_p0   = pack_q28(1'b0, w_ls[QW].ovf, w_qquo[0][QW]);
        w_p1   = pack_q28(w_s1[QW].neg, w_s1[QW].ovf, w_qquo[1][QW]);
        w_p2   = pack_q28(w_s2[QW].neg, w_s2[QW].ovf, w_qquo[2][QW]);
        w_sat  = w_p0.sat || w_p1.sat || w_p2.sat;
        w_zero = (w_ls[QW].pre != ncg_pkg::ST_OK);
    end

    always_ff @(posedge i_clk) begin
        o_num_outer  <= w_zero ? '0 : w_p0.val;
        o_num_middle <= w_zero ? '0 : w_p1.val;
        o_den_first  <= w_zero ? '0 : w_p1.val;
        o_den_second <= w_zero ? '0 : w_p2.val;
        if (w_zero) begin
            o_status <= w_ls[QW].pre;
        end else if (w_sat) begin
            o_status <= ncg_pkg::ST_SAT;
        end else begin
            o_status <= ncg_pkg::ST_OK;
        end
    end

    // valid bits of the single stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th_vld       <= 1'b0;
            r_cl_vld       <= 1'b0;
            r_m_vld        <= 1'b0;
            r_pt_vld       <= 1'b0;
            r_nm_vld       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_th_vld       <= w_rv[QW];
            r_cl_vld       <= w_cv[TAN_STAGES];
            r_m_vld        <= r_cl_vld;
            r_pt_vld       <= r_m_vld;
            r_nm_vld       <= r_pt_vld;
            o_result_valid <= w_qv[QW];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    `NCG_ASSERT(a_latency, (start && !busy) |-> ##LAT o_result_valid, "result missing")
    `NCG_ASSERT_IMPLY(a_half_zero, o_result_valid && (o_status == ncg_pkg::ST_HALF), (o_num_outer == '0) && (o_den_second == '0), "half rate not zeroed")
    `NCG_ASSERT_IMPLY(a_b0_pos, o_result_valid && (o_status == ncg_pkg::ST_OK), !o_num_outer[31], "b0 negative")
    `NCG_ASSERT_IMPLY(a_chain_sync, r_pt_vld, r_m_vld == $past(r_cl_vld), "stage valid out of step")

endmodule

`default_nettype wire

[tb/sv/tb_notch_coefficient_generator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_notch_coefficient_generator
// Self-checking bench for the notch coefficient generator: a directed table
// over rate, frequency and damping extremes, then random retune requests in
// several idling phases. Every result is compared with a bit-exact predictor or a typed table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_notch_coefficient_generator;

    localparam int TAIL_CYCLES = ncg_pkg::TAN_STAGES_DEF + 100;

    typedef struct packed {
        logic signed [ncg_pkg::COEF_W-1:0] b0;
        logic signed [ncg_pkg::COEF_W-1:0] b1;
        logic signed [ncg_pkg::COEF_W-1:0] a1;
        logic signed [ncg_pkg::COEF_W-1:0] a2;
        ncg_pkg::t_status                  status;
    } t_coef_set;

    typedef struct {
        logic [ncg_pkg::RATE_W-1:0] rate;
        logic [ncg_pkg::FREQ_W-1:0] freq;
        logic [ncg_pkg::DAMP_W-1:0] damp;
        bit                         typed;
        t_coef_set                  coefs;
    } t_retune_row;

    localparam t_coef_set HALF_RATE_SET = '{0, 0, 0, 0, ncg_pkg::ST_HALF};

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [ncg_pkg::FREQ_W-1:0]           i_notch_freq;
    logic [ncg_pkg::DAMP_W-1:0]           i_damping;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [ncg_pkg::RATE_W-1:0]           i_cfg_data;
    logic                                 o_result_valid;
    logic signed [ncg_pkg::COEF_W-1:0]    o_num_outer;
    logic signed [ncg_pkg::COEF_W-1:0]    o_num_middle;
    logic signed [ncg_pkg::COEF_W-1:0]    o_den_first;
    logic signed [ncg_pkg::COEF_W-1:0]    o_den_second;
    logic [1:0]                           o_status;

    // expectation that rides along with the item being offered
    logic                                 item_typed;
    t_coef_set                            item_coefs;

    logic [ncg_pkg::RATE_W-1:0]           rate_now;
    t_coef_set                            pending_coefs[$];
    int                                   mismatch_count = 0;
    int                                   result_count = 0;
    int                                   idle_pct;

    notch_coefficient_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_notch_freq   (i_notch_freq),
        .i_damping      (i_damping),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_num_outer    (o_num_outer),
        .o_num_middle   (o_num_middle),
        .o_den_first    (o_den_first),
        .o_den_second   (o_den_second),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Rounded Q28 magnitude of n/d, 2^32 when the quotient reaches 8
    function automatic logic [65:0] ratio_q28(logic [65:0] n, logic [65:0] d);
        logic [65:0] q;
        logic [65:0] rem;
        q   = n / d;
        rem = n % d;
        if (q >= 8) return 66'd1 << 32;
        for (int i = 0; i < 29; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return (q + 1) >> 1;
    endfunction

    // Signed Q3.28 from sign and magnitude, clamped at the range limits
    function automatic logic [ncg_pkg::COEF_W-1:0] to_q328(bit neg, logic [65:0] mag,
                                                           inout bit sat);
        logic [65:0] m;
        m = mag;
        if (!neg) begin
            if (m > 66'h7FFF_FFFF) begin
                sat = 1'b1;
                m   = 66'h7FFF_FFFF;
            end
            return m[ncg_pkg::COEF_W-1:0];
        end
        if (m > 66'h8000_0000) begin
            sat = 1'b1;
            m   = 66'h8000_0000;
        end
        return -m[ncg_pkg::COEF_W-1:0];
    endfunction

    // Notch coefficients: CORDIC sin/cos, then every ratio over d = 2560 * p + t
    function automatic t_coef_set notch_coefs(logic [ncg_pkg::RATE_W-1:0] fs,
                                              logic [ncg_pkg::FREQ_W-1:0] f,
                                              logic [ncg_pkg::DAMP_W-1:0] damp);
        t_coef_set   res;
        logic [63:0] r;
        logic [63:0] prod;
        longint      x;
        longint      y;
        longint      z;
        longint      xn;
        longint      a;
        logic [65:0] s;
        logic [65:0] c;
        logic [65:0] s2;
        logic [65:0] c2;
        logic [65:0] p;
        logic [65:0] t;
        logic [65:0] d;
        bit          sat;
        bit          neg;
        res = '{0, 0, 0, 0, ncg_pkg::ST_OK};
        sat = 1'b0;
        if (fs == 0 || {40'd0, f} >= ({48'd0, fs} << 7)) begin
            res.status = ncg_pkg::ST_HALF;
            return res;
        end
        r    = ({40'd0, f} << 25) / {48'd0, fs};
        prod = r * {32'd0, ncg_pkg::HALF_PI_Q30};
        z    = longint'(prod >> 32);
        x    = 64'sd1 << 29;
        y    = 0;
        for (int i = 0; i < ncg_pkg::TAN_STAGES_DEF; i++) begin
            a = longint'({32'd0, ncg_pkg::ATAN_Q30[i]});
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - a;
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + a;
            end
            x = xn;
        end
        c  = (x > 0) ? 66'(x) >> 7 : 66'd0;
        s  = (y > 0) ? 66'(y) >> 7 : 66'd0;
        s2 = s * s;
        c2 = c * c;
        p  = s2 + c2;
        t  = 66'(damp) * s * c;
        d  = 2560 * p + t;
        if (d == 0) begin
            res.status = ncg_pkg::ST_DZERO;
            return res;
        end
        res.b0 = to_q328(1'b0, ratio_q28(2560 * p, d), sat);
        neg    = s2 < c2;
        res.b1 = to_q328(neg, ratio_q28(5120 * (neg ? c2 - s2 : s2 - c2), d), sat);
        res.a1 = res.b1;
        neg    = t > 2560 * p;
        res.a2 = to_q328(neg, ratio_q28(neg ? t - 2560 * p : 2560 * p - t, d), sat);
        res.status = sat ? ncg_pkg::ST_SAT : ncg_pkg::ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("MISMATCH %s at %0t", msg, $realtime);
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h, expected %h", field, got, want));
    endtask

    // Accepted items and rate writes, seen at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_now <= 16'd1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) rate_now <= i_cfg_data;
            if (start && !busy) begin
                if (item_typed) pending_coefs.push_back(item_coefs);
                else pending_coefs.push_back(notch_coefs(rate_now, i_notch_freq,
                                                         i_damping));
            end
        end
    end

    // Result strobe check against the oldest expectation
    always @(posedge i_clk) begin
        t_coef_set want;
        if (i_rst_n && o_result_valid) begin
            result_count++;
            if (pending_coefs.size() == 0) begin
                report_mismatch("unexpected result");
            end else begin
                want = pending_coefs.pop_front();
                check_field("num_outer", o_num_outer, want.b0);
                check_field("num_middle", o_num_middle, want.b1);
                check_field("den_first", o_den_first, want.a1);
                check_field("den_second", o_den_second, want.a2);
                check_field("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    // Offer one item, with random idle cycles ahead of it
    task automatic send_item(logic [ncg_pkg::FREQ_W-1:0] f,
                             logic [ncg_pkg::DAMP_W-1:0] damp,
                             bit typed, t_coef_set coefs);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_notch_freq <= f;
        i_damping    <= damp;
        item_typed   <= typed;
        item_coefs   <= coefs;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Let the pipeline run dry
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_coefs.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [ncg_pkg::RATE_W-1:0] fs);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fs;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    t_retune_row retune_table[] = '{
        '{16'd1,     24'd0,        16'd0,     1'b0, '0},
        '{16'd1,     24'd127,      16'hFFFF,  1'b0, '0},
        '{16'd1,     24'd128,      16'd5120,  1'b1, HALF_RATE_SET},
        '{16'd1,     24'hFFFFFF,   16'hFFFF,  1'b1, HALF_RATE_SET},
        '{16'd48000, 24'd0,        16'd5120,  1'b0, '0},
        '{16'd48000, 24'd256000,   16'd0,     1'b0, '0},
        '{16'd48000, 24'd256000,   16'hFFFF,  1'b0, '0},
        '{16'd48000, 24'd6143999,  16'd1,     1'b0, '0},
        '{16'd48000, 24'd6143999,  16'hFFFF,  1'b0, '0},
        '{16'd48000, 24'd6144000,  16'd100,   1'b1, HALF_RATE_SET},
        '{16'd48000, 24'h555555,   16'hAAAA,  1'b0, '0},
        '{16'd48000, 24'h2AAAAA,   16'h5555,  1'b0, '0},
        '{16'd48000, 24'd3072000,  16'd2560,  1'b0, '0},
        '{16'd65535, 24'd1,        16'd0,     1'b0, '0},
        '{16'd65535, 24'd8388479,  16'hFFFF,  1'b0, '0},
        '{16'd65535, 24'd8388480,  16'd0,     1'b1, HALF_RATE_SET},
        '{16'd65535, 24'hFFFFFF,   16'd1,     1'b1, HALF_RATE_SET},
        '{16'd65535, 24'd4194240,  16'h8000,  1'b0, '0},
        '{16'd0,     24'd0,        16'd0,     1'b1, HALF_RATE_SET},
        '{16'd0,     24'h123456,   16'hFFFF,  1'b1, HALF_RATE_SET},
        '{16'd2,     24'd255,      16'd7,     1'b0, '0},
        '{16'd2,     24'd128,      16'd0,     1'b0, '0}
    };

    initial begin
        logic [ncg_pkg::RATE_W-1:0] fs;
        logic [ncg_pkg::FREQ_W-1:0] f;
        int                         phase_pct[4] = '{0, 57, 17, 0};
        start          = 1'b0;
        i_notch_freq   = '0;
        i_damping      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        item_typed     = 1'b0;
        item_coefs     = '0;
        idle_pct       = 0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; first rows run at the reset rate
        fs = 16'd1;
        foreach (retune_table[i]) begin
            if (retune_table[i].rate != fs) begin
                drain();
                fs = retune_table[i].rate;
                write_rate(fs);
            end
            idle_pct = (i % 2) ? 57 : 0;
            send_item(retune_table[i].freq, retune_table[i].damp,
                      retune_table[i].typed, retune_table[i].coefs);
        end

        // random phases, each with a few rate settings
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_pct[ph];
            for (int blk = 0; blk < 5; blk++) begin
                drain();
                case ($urandom_range(4))
                    0: fs = 16'd1;
                    1: fs = 16'hFFFF;
                    default: fs = 16'($urandom_range(1, 65535));
                endcase
                write_rate(fs);
                for (int k = 0; k < 45; k++) begin
                    // mostly below half rate, some anywhere in the field
                    if ($urandom_range(9) < 8)
                        f = 24'($urandom_range(0, 32'(fs) * 128 - 1));
                    else
                        f = 24'($urandom);
                    if (ph == 3 && blk == 0) idle_pct = (k < 20) ? 0 : 57;
                    send_item(f, 16'($urandom), 1'b0, '0);
                end
            end
        end
        drain();

        $display("Covered %0d results over directed rate/frequency/damping extremes", result_count);
        $display("and random retunes at several rates with and without idle gaps.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
